@@ hdl/bivh_pkg.sv @@
// Shared types and constants of the beat interval gate and HRV statistics block.
package bivh_pkg;

	localparam int IVAL_W  = 11;
	localparam int IN_W    = 16;
	localparam int QUAL_W  = 8;
	localparam int TIME_W  = 32;
	localparam int STALE_W = 16;
	localparam int TALLY_W = 32;
	localparam int HELD_W  = 9;
	localparam int VAR_W   = 21;
	localparam int MAD_W   = 2 * IVAL_W;
	localparam int APB_AW  = 4;
	localparam int APB_DW  = 32;

	localparam logic [VAR_W-1:0]   VAR_MAX     = '1;
	localparam logic [IVAL_W+2:0]  JUMP_FACTOR = 14'd5;
	localparam logic [STALE_W-1:0] RESET_STALE = 16'd10;
	localparam logic [IVAL_W-1:0]  RESET_MIN   = 11'd300;
	localparam logic [IVAL_W-1:0]  RESET_MAX   = 11'd2000;

	localparam logic [1:0] REG_STALE = 2'd0;
	localparam logic [1:0] REG_MIN   = 2'd1;
	localparam logic [1:0] REG_MAX   = 2'd2;

	localparam logic [1:0] REASON_NONE    = 2'd0;
	localparam logic [1:0] REASON_QUALITY = 2'd1;
	localparam logic [1:0] REASON_RANGE   = 2'd2;
	localparam logic [1:0] REASON_JUMP    = 2'd3;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_CLEAR  = 2'd1,
		CMD_REPORT = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [STALE_W-1:0] stale;
		logic [IVAL_W-1:0]  min_ms;
		logic [IVAL_W-1:0]  max_ms;
	} cfg_t;

	typedef struct packed {
		cmd_t              cmd;
		logic              quality_bad;
		logic              range_bad;
		logic [IVAL_W-1:0] interval;
		logic [TIME_W-1:0] time_s;
	} item_t;

	typedef struct packed {
		logic               accepted;
		logic [1:0]         reject_reason;
		logic [HELD_W-1:0]  entries_held;
		logic [IVAL_W-1:0]  mean_interval;
		logic [IVAL_W-1:0]  rmssd_value;
		logic [IVAL_W-1:0]  sdnn_value;
		logic [VAR_W-1:0]   interval_variance;
		logic [MAD_W-1:0]   mad_squared;
		logic [TALLY_W-1:0] quality_rejections;
		logic [TALLY_W-1:0] range_rejections;
		logic [TALLY_W-1:0] jump_rejections;
		logic [TALLY_W-1:0] accepted_total;
	} result_t;

endpackage

@@ hdl/bivh_div.sv @@
// Restoring divider, one quotient bit per cycle.
module bivh_div #(
	parameter int DVD_W = 31,
	parameter int DVS_W = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W:0]   rem_sh;
	logic [DVS_W:0]   rem_sub;
	logic             ge;

	always_comb begin
		rem_sh  = {rem_q, quo_q[DVD_W-1]};
		ge      = rem_sh >= {1'b0, dvs_q};
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			dvs_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DVD_W);
				dvs_q <= divisor;
				rem_q <= '0;
				quo_q <= dividend;
			end else if (run_q) begin
				rem_q <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ hdl/bivh_sqrt.sv @@
// Floor square root, one root bit per cycle.
module bivh_sqrt (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [bivh_pkg::MAD_W-1:0]  radicand,
	output logic                 done,
	output logic [bivh_pkg::IVAL_W-1:0] root
);
	import bivh_pkg::*;

	logic              run_q;
	logic              done_q;
	logic [MAD_W-1:0]  rad_q;
	logic [IVAL_W-1:0] root_q;
	logic [IVAL_W-1:0] bit_q;
	logic [IVAL_W-1:0] trial;
	logic [MAD_W-1:0]  trial_sq;

	always_comb begin
		trial    = root_q | bit_q;
		trial_sq = MAD_W'(trial) * MAD_W'(trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			rad_q  <= '0;
			root_q <= '0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				rad_q  <= radicand;
				root_q <= '0;
				bit_q  <= IVAL_W'(1) << (IVAL_W - 1);
			end else if (run_q) begin
				if (trial_sq <= rad_q) begin
					root_q <= trial;
				end
				bit_q <= bit_q >> 1;
				if (bit_q[0]) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

@@ hdl/bivh_front.sv @@
// Front end: input queue that decodes, quality-screens and range-screens each item.
module bivh_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [1:0]           command,
	input  logic [bivh_pkg::IN_W-1:0]   interval_ms,
	input  logic [bivh_pkg::QUAL_W-1:0] quality,
	input  logic [bivh_pkg::TIME_W-1:0] time_s,
	input  bivh_pkg::cfg_t       cfg,
	output logic                 item_valid,
	output bivh_pkg::item_t      item,
	input  logic                 item_take
);
	import bivh_pkg::*;

	item_t      q_mem [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	item_t      item_in;
	logic       wr_en;

	always_comb begin
		item_in.cmd         = cmd_t'(command);
		item_in.quality_bad = quality == '0;
		item_in.range_bad   = (interval_ms < IN_W'(cfg.min_ms)) ||
			(interval_ms > IN_W'(cfg.max_ms));
		item_in.interval    = interval_ms[IVAL_W-1:0];
		item_in.time_s      = time_s;
	end

	assign full       = cnt_q == 2'd2;
	assign wr_en      = push && !full;
	assign item_valid = cnt_q != 2'd0;
	assign item       = q_mem[rd_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			q_mem[wr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_q <= !wr_q;
			end
			if (item_take) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, item_take};
		end
	end

endmodule

@@ hdl/bivh_back.sv @@
// Back end: window store, gate, tallies, report passes and result queue.
module bivh_back #(
	parameter int WINDOW_DEPTH = 400
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bivh_pkg::cfg_t       cfg,
	input  logic                 item_valid,
	input  bivh_pkg::item_t      item,
	output logic                 item_take,
	input  logic                 pop,
	output logic                 empty,
	output bivh_pkg::result_t    result
);
	import bivh_pkg::*;

	localparam int ADDR_W = $clog2(WINDOW_DEPTH);
	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W  = IVAL_W + CNT_W;
	localparam int SQ_W   = MAD_W + CNT_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SUM, ST_DIV_MEAN, ST_DIV_RMS, ST_SQRT_RMS,
		ST_VAR, ST_DIV_VAR, ST_SQRT_VAR, ST_SEL, ST_FINISH
	} state_t;

	function automatic logic [IVAL_W-1:0] abs_diff(input logic [IVAL_W-1:0] a,
		input logic [IVAL_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	state_t state_q;

	// window store
	logic [IVAL_W-1:0] win_mem [WINDOW_DEPTH];
	logic [IVAL_W-1:0] rd_data_s1;
	logic [ADDR_W-1:0] rd_addr_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;

	// block state
	logic [CNT_W-1:0]   fill_q;
	logic [ADDR_W-1:0]  oldest_q;
	logic [IVAL_W-1:0]  pint_q;
	logic [TIME_W-1:0]  ptime_q;
	logic [TALLY_W-1:0] tq_q, tr_q, tj_q, ta_q;

	// next values for a taken item
	logic [CNT_W-1:0]   nxt_fill;
	logic [ADDR_W-1:0]  nxt_oldest;
	logic [IVAL_W-1:0]  nxt_pint;
	logic [TIME_W-1:0]  nxt_ptime;
	logic [TALLY_W-1:0] nxt_tq, nxt_tr, nxt_tj, nxt_ta;
	logic [1:0]         nxt_reason;
	logic               nxt_acc;
	logic               fresh;
	logic               jump;
	logic [CNT_W:0]     slot_sum;
	logic [ADDR_W-1:0]  tail_slot;
	logic [ADDR_W-1:0]  oldest_inc;

	// report datapath
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  issue_k_q;
	logic              issuing_q;
	logic              v_s1;
	logic              first_s1;
	logic              v_s2;
	logic [MAD_W-1:0]  sq_s2;
	logic [IVAL_W-1:0] prev_e_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SQ_W-1:0]   acc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IVAL_W-1:0] prefix_q;
	logic [IVAL_W-1:0] bit_q;
	logic              mad_phase_q;
	logic [IVAL_W-1:0] med_q;
	logic [IVAL_W-1:0] mean_q;
	logic [IVAL_W-1:0] rms_q;
	logic [IVAL_W-1:0] sdnn_q;
	logic [VAR_W-1:0]  var_q;
	logic [IVAL_W-1:0] mad_dev_q;
	logic [ADDR_W-1:0] addr_inc;
	logic              pass_done;
	logic [IVAL_W-1:0] cand;
	logic [IVAL_W-1:0] sel_val;
	logic [IVAL_W-1:0] prefix_nxt;
	logic [IVAL_W-1:0] d_succ;
	logic [IVAL_W-1:0] d_mean;

	// shared units
	logic             div_start_q;
	logic [SQ_W-1:0]  div_dvd_q;
	logic [CNT_W-1:0] div_dvs_q;
	logic             div_done;
	logic [SQ_W-1:0]  div_quo;
	logic             sqrt_start_q;
	logic [MAD_W-1:0] sqrt_rad_q;
	logic             sqrt_done;
	logic [IVAL_W-1:0] sqrt_root;

	// result queue
	result_t res_mem [2];
	result_t res_new_q;
	logic    res_push_q;
	logic    res_wr_q;
	logic    res_rd_q;
	logic [1:0] res_cnt_q;
	logic    res_free;
	logic    res_pop;

	bivh_div #(.DVD_W(SQ_W), .DVS_W(CNT_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_dvd_q),
		.divisor  (div_dvs_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	bivh_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start_q),
		.radicand (sqrt_rad_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	assign res_free  = (res_cnt_q == 2'd0) || (res_cnt_q == 2'd1 && !res_push_q);
	assign item_take = (state_q == ST_IDLE) && item_valid && res_free;

	always_comb begin
		slot_sum   = {1'b0, CNT_W'(oldest_q)} + {1'b0, fill_q};
		tail_slot  = (slot_sum >= (CNT_W+1)'(WINDOW_DEPTH)) ?
			ADDR_W'(slot_sum - (CNT_W+1)'(WINDOW_DEPTH)) : ADDR_W'(slot_sum);
		oldest_inc = (oldest_q == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_q + 1'b1;
		fresh      = (ptime_q != '0) &&
			((item.time_s - ptime_q) <= TIME_W'(cfg.stale));
		jump       = (pint_q != '0) && fresh &&
			((JUMP_FACTOR * (IVAL_W+3)'(abs_diff(item.interval, pint_q))) >
			(IVAL_W+3)'(pint_q));

		nxt_fill   = fill_q;
		nxt_oldest = oldest_q;
		nxt_pint   = pint_q;
		nxt_ptime  = ptime_q;
		nxt_tq     = tq_q;
		nxt_tr     = tr_q;
		nxt_tj     = tj_q;
		nxt_ta     = ta_q;
		nxt_reason = REASON_NONE;
		nxt_acc    = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = tail_slot;
		if (item_take) begin
			unique case (item.cmd)
				CMD_ADD: begin
					priority if (item.quality_bad) begin
						nxt_reason = REASON_QUALITY;
						nxt_tq     = tq_q + 1'b1;
					end else if (item.range_bad) begin
						nxt_reason = REASON_RANGE;
						nxt_tr     = tr_q + 1'b1;
					end else if (jump) begin
						nxt_reason = REASON_JUMP;
						nxt_tj     = tj_q + 1'b1;
					end else begin
						nxt_acc   = 1'b1;
						mem_we    = 1'b1;
						nxt_pint  = item.interval;
						nxt_ptime = item.time_s;
						nxt_ta    = ta_q + 1'b1;
						if (fill_q == CNT_W'(WINDOW_DEPTH)) begin
							mem_waddr  = oldest_q;
							nxt_oldest = oldest_inc;
						end else begin
							nxt_fill = fill_q + 1'b1;
						end
					end
				end
				CMD_CLEAR: begin
					nxt_fill   = '0;
					nxt_oldest = '0;
					nxt_pint   = '0;
					nxt_ptime  = '0;
					nxt_tq     = '0;
					nxt_tr     = '0;
					nxt_tj     = '0;
					nxt_ta     = '0;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		addr_inc   = (rd_addr_q == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : rd_addr_q + 1'b1;
		pass_done  = !issuing_q && !v_s1 && !v_s2;
		d_succ     = abs_diff(rd_data_s1, prev_e_q);
		d_mean     = abs_diff(rd_data_s1, mean_q);
		cand       = prefix_q | bit_q;
		sel_val    = mad_phase_q ? abs_diff(rd_data_s1, med_q) : rd_data_s1;
		// keep the bit while no more than n/2 entries lie below the candidate
		prefix_nxt = (cnt_q <= (n_q >> 1)) ? cand : prefix_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			win_mem[mem_waddr] <= item.interval;
		end
		rd_data_s1 <= win_mem[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_q       <= '0;
			oldest_q     <= '0;
			pint_q       <= '0;
			ptime_q      <= '0;
			tq_q         <= '0;
			tr_q         <= '0;
			tj_q         <= '0;
			ta_q         <= '0;
			n_q          <= '0;
			issue_k_q    <= '0;
			issuing_q    <= 1'b0;
			rd_addr_q    <= '0;
			v_s1         <= 1'b0;
			first_s1     <= 1'b0;
			v_s2         <= 1'b0;
			sq_s2        <= '0;
			prev_e_q     <= '0;
			sum_q        <= '0;
			acc_q        <= '0;
			cnt_q        <= '0;
			prefix_q     <= '0;
			bit_q        <= '0;
			mad_phase_q  <= 1'b0;
			med_q        <= '0;
			mean_q       <= '0;
			rms_q        <= '0;
			sdnn_q       <= '0;
			var_q        <= '0;
			mad_dev_q    <= '0;
			div_start_q  <= 1'b0;
			div_dvd_q    <= '0;
			div_dvs_q    <= '0;
			sqrt_start_q <= 1'b0;
			sqrt_rad_q   <= '0;
			res_new_q    <= '0;
			res_push_q   <= 1'b0;
		end else begin
			div_start_q  <= 1'b0;
			sqrt_start_q <= 1'b0;
			res_push_q   <= 1'b0;
			v_s2         <= 1'b0;

			// window read sweep, oldest entry first
			if (issuing_q) begin
				v_s1      <= 1'b1;
				first_s1  <= issue_k_q == '0;
				rd_addr_q <= addr_inc;
				issue_k_q <= issue_k_q + 1'b1;
				if (issue_k_q == n_q - 1'b1) begin
					issuing_q <= 1'b0;
				end
			end else begin
				v_s1 <= 1'b0;
			end
			if (v_s2) begin
				acc_q <= acc_q + SQ_W'(sq_s2);
			end

			unique case (state_q)
				ST_IDLE: begin
					if (item_take) begin
						fill_q   <= nxt_fill;
						oldest_q <= nxt_oldest;
						pint_q   <= nxt_pint;
						ptime_q  <= nxt_ptime;
						tq_q     <= nxt_tq;
						tr_q     <= nxt_tr;
						tj_q     <= nxt_tj;
						ta_q     <= nxt_ta;
						res_new_q <= '{accepted: nxt_acc, reject_reason: nxt_reason,
							entries_held: HELD_W'(nxt_fill), mean_interval: '0,
							rmssd_value: '0, sdnn_value: '0, interval_variance: '0,
							mad_squared: '0, quality_rejections: nxt_tq,
							range_rejections: nxt_tr, jump_rejections: nxt_tj,
							accepted_total: nxt_ta};
						mean_q    <= '0;
						rms_q     <= '0;
						sdnn_q    <= '0;
						var_q     <= '0;
						mad_dev_q <= '0;
						if (item.cmd == CMD_REPORT && fill_q != '0) begin
							n_q       <= fill_q;
							sum_q     <= '0;
							acc_q     <= '0;
							issue_k_q <= '0;
							rd_addr_q <= oldest_q;
							issuing_q <= 1'b1;
							state_q   <= ST_SUM;
						end else begin
							res_push_q <= 1'b1;
						end
					end
				end
				ST_SUM: begin
					if (v_s1) begin
						sum_q    <= sum_q + SUM_W'(rd_data_s1);
						prev_e_q <= rd_data_s1;
						if (!first_s1) begin
							sq_s2 <= MAD_W'(d_succ) * MAD_W'(d_succ);
							v_s2  <= 1'b1;
						end
					end
					if (pass_done) begin
						div_start_q <= 1'b1;
						div_dvd_q   <= SQ_W'(sum_q);
						div_dvs_q   <= n_q;
						state_q     <= ST_DIV_MEAN;
					end
				end
				ST_DIV_MEAN: begin
					if (div_done) begin
						mean_q <= div_quo[IVAL_W-1:0];
						if (n_q == CNT_W'(1)) begin
							state_q <= ST_FINISH;
						end else begin
							div_start_q <= 1'b1;
							div_dvd_q   <= acc_q;
							div_dvs_q   <= n_q - 1'b1;
							state_q     <= ST_DIV_RMS;
						end
					end
				end
				ST_DIV_RMS: begin
					if (div_done) begin
						sqrt_start_q <= 1'b1;
						sqrt_rad_q   <= div_quo[MAD_W-1:0];
						state_q      <= ST_SQRT_RMS;
					end
				end
				ST_SQRT_RMS: begin
					if (sqrt_done) begin
						rms_q     <= sqrt_root;
						acc_q     <= '0;
						issue_k_q <= '0;
						rd_addr_q <= oldest_q;
						issuing_q <= 1'b1;
						state_q   <= ST_VAR;
					end
				end
				ST_VAR: begin
					if (v_s1) begin
						sq_s2 <= MAD_W'(d_mean) * MAD_W'(d_mean);
						v_s2  <= 1'b1;
					end
					if (pass_done) begin
						div_start_q <= 1'b1;
						div_dvd_q   <= acc_q;
						div_dvs_q   <= n_q - 1'b1;
						state_q     <= ST_DIV_VAR;
					end
				end
				ST_DIV_VAR: begin
					if (div_done) begin
						var_q        <= (div_quo > SQ_W'(VAR_MAX)) ? VAR_MAX :
							div_quo[VAR_W-1:0];
						sqrt_start_q <= 1'b1;
						sqrt_rad_q   <= (div_quo > SQ_W'(VAR_MAX)) ? MAD_W'(VAR_MAX) :
							MAD_W'(div_quo[VAR_W-1:0]);
						state_q      <= ST_SQRT_VAR;
					end
				end
				ST_SQRT_VAR: begin
					if (sqrt_done) begin
						sdnn_q      <= sqrt_root;
						mad_phase_q <= 1'b0;
						prefix_q    <= '0;
						bit_q       <= IVAL_W'(1) << (IVAL_W - 1);
						cnt_q       <= '0;
						issue_k_q   <= '0;
						rd_addr_q   <= oldest_q;
						issuing_q   <= 1'b1;
						state_q     <= ST_SEL;
					end
				end
				ST_SEL: begin
					// one sweep per result bit: median, then median deviation
					if (v_s1 && sel_val < cand) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (pass_done) begin
						cnt_q     <= '0;
						issue_k_q <= '0;
						rd_addr_q <= oldest_q;
						if (bit_q[0]) begin
							if (!mad_phase_q) begin
								med_q       <= prefix_nxt;
								mad_phase_q <= 1'b1;
								prefix_q    <= '0;
								bit_q       <= IVAL_W'(1) << (IVAL_W - 1);
								issuing_q   <= 1'b1;
							end else begin
								mad_dev_q <= prefix_nxt;
								state_q   <= ST_FINISH;
							end
						end else begin
							prefix_q  <= prefix_nxt;
							bit_q     <= bit_q >> 1;
							issuing_q <= 1'b1;
						end
					end
				end
				ST_FINISH: begin
					res_new_q <= '{accepted: 1'b0, reject_reason: REASON_NONE,
						entries_held: HELD_W'(fill_q), mean_interval: mean_q,
						rmssd_value: rms_q, sdnn_value: sdnn_q, interval_variance: var_q,
						mad_squared: MAD_W'(mad_dev_q) * MAD_W'(mad_dev_q),
						quality_rejections: tq_q, range_rejections: tr_q,
						jump_rejections: tj_q, accepted_total: ta_q};
					res_push_q <= 1'b1;
					state_q    <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result queue, two items
	assign empty   = res_cnt_q == 2'd0;
	assign res_pop = pop && !empty;
	assign result  = res_mem[res_rd_q];

	always_ff @(posedge clk) begin
		if (res_push_q) begin
			res_mem[res_wr_q] <= res_new_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= 1'b0;
			res_rd_q  <= 1'b0;
			res_cnt_q <= 2'd0;
		end else begin
			if (res_push_q) begin
				res_wr_q <= !res_wr_q;
			end
			if (res_pop) begin
				res_rd_q <= !res_rd_q;
			end
			res_cnt_q <= res_cnt_q + {1'b0, res_push_q} - {1'b0, res_pop};
		end
	end

endmodule

@@ hdl/beat_interval_gate_hrv_stats_top.sv @@
// Add/clear/other: the result passes res_new_q into the result queue; a new item can
// be taken before the last result is queued, while the queue has room. Report over
// n >= 2 entries: window sweeps on the one memory read port (two statistic sweeps
// and 22 median-select sweeps), three bit-serial divides and two square roots.
// Reset (arst_n low, asynchronous): empty window, tallies zero, registers at
// their reset values; the window memory is not cleared and needs no clearing pass.
module beat_interval_gate_hrv_stats_top #(
	parameter int WINDOW_DEPTH = 400
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  command,
	input  logic [15:0] interval_ms,
	input  logic [7:0]  quality,
	input  logic [31:0] time_s,
	output logic        empty,
	input  logic        pop,
	output logic        accepted,
	output logic [1:0]  reject_reason,
	output logic [8:0]  entries_held,
	output logic [10:0] mean_interval,
	output logic [10:0] rmssd_value,
	output logic [10:0] sdnn_value,
	output logic [20:0] interval_variance,
	output logic [21:0] mad_squared,
	output logic [31:0] quality_rejections,
	output logic [31:0] range_rejections,
	output logic [31:0] jump_rejections,
	output logic [31:0] accepted_total,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bivh_pkg::*;

	cfg_t    cfg_q;
	item_t   item;
	logic    item_valid;
	logic    item_take;
	result_t result;
	logic    cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stale  <= RESET_STALE;
			cfg_q.min_ms <= RESET_MIN;
			cfg_q.max_ms <= RESET_MAX;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				REG_STALE: cfg_q.stale  <= pwdata[STALE_W-1:0];
				REG_MIN:   cfg_q.min_ms <= pwdata[IVAL_W-1:0];
				REG_MAX:   cfg_q.max_ms <= pwdata[IVAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_STALE: prdata = APB_DW'(cfg_q.stale);
			REG_MIN:   prdata = APB_DW'(cfg_q.min_ms);
			REG_MAX:   prdata = APB_DW'(cfg_q.max_ms);
			default:   prdata = '0;
		endcase
	end

	bivh_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.command     (command),
		.interval_ms (interval_ms),
		.quality     (quality),
		.time_s      (time_s),
		.cfg         (cfg_q),
		.item_valid  (item_valid),
		.item        (item),
		.item_take   (item_take)
	);

	bivh_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

	assign accepted           = result.accepted;
	assign reject_reason      = result.reject_reason;
	assign entries_held       = result.entries_held;
	assign mean_interval      = result.mean_interval;
	assign rmssd_value        = result.rmssd_value;
	assign sdnn_value         = result.sdnn_value;
	assign interval_variance  = result.interval_variance;
	assign mad_squared        = result.mad_squared;
	assign quality_rejections = result.quality_rejections;
	assign range_rejections   = result.range_rejections;
	assign jump_rejections    = result.jump_rejections;
	assign accepted_total     = result.accepted_total;

`ifndef SYNTHESIS
	a_accept_no_reason: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && accepted) |-> (reject_reason == REASON_NONE))
		else $error("accepted item carries a reject reason");
	a_add_no_stats: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && accepted) |-> (mean_interval == '0 && mad_squared == '0))
		else $error("add result carries statistics");
	a_sdnn_var: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && sdnn_value != '0) |-> (interval_variance != '0))
		else $error("sdnn without variance");
	a_take_room: assert property (@(posedge clk) disable iff (!arst_n)
		item_take |-> item_valid)
		else $error("back end took from an empty front queue");
`endif

endmodule
